### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared helpers for concurrent checks with a synchronous active-high reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/iir_pkg.sv
// ----------------------------------------------------------------------------
// iir_pkg
// types, register map and microcode table of the direct form II iir filter
// ----------------------------------------------------------------------------
`default_nettype none

package iir_pkg;

   // filter order default
   localparam int DefFilterOrder = 3;

   // widths
   localparam int SampleW = 24;
   localparam int CoefW   = 32;
   localparam int DelayW  = 40;
   localparam int AccW    = 48;
   localparam int FracW   = 8;
   localparam int CoefFrac = 27;
   localparam int SplitW  = 20;
   localparam int ProdW   = CoefW + DelayW;
   localparam int NumRegs = 8;
   localparam int AddrW   = 5;
   localparam int DataW   = 32;

   // register reset values
   localparam logic signed [CoefW-1:0] CoefB0Reset = 32'sd134217728;

   // input and result items
   typedef struct packed {
      logic signed [SampleW-1:0] sample_in;
      logic                      last_of_batch;
   } req_type;

   typedef struct packed {
      logic signed [SampleW-1:0] sample_out;
      logic                      clipped;
   } rsp_type;

   // register indexes
   typedef enum logic [2:0] {
      REG_B0   = 3'd0,
      REG_B1   = 3'd1,
      REG_B2   = 3'd2,
      REG_B3   = 3'd3,
      REG_A1   = 3'd4,
      REG_A2   = 3'd5,
      REG_A3   = 3'd6,
      REG_KEEP = 3'd7
   } reg_idx_type;

   // multiplier operand select
   typedef enum logic [1:0] {
      OPND_D0 = 2'd0,
      OPND_D1 = 2'd1,
      OPND_D2 = 2'd2,
      OPND_W  = 2'd3
   } opnd_type;

   // accumulate operation on the product registered one step earlier
   typedef enum logic [1:0] {
      ACC_NONE   = 2'd0,
      ACC_FB_SUB = 2'd1,
      ACC_Y_ADD  = 2'd2
   } acc_op_type;

   // one control word
   typedef struct packed {
      logic        mul_en;
      reg_idx_type coef;
      opnd_type    opnd;
      acc_op_type  acc_op;
      logic        w_load;
      logic        hold_if_full;
      logic        finish;
   } ucode_type;

   localparam int UcodeSteps = 9;
   localparam int StepW      = $clog2(UcodeSteps);

   // microcode program, one control word per step
   function automatic ucode_type ucode_rom(input logic [StepW-1:0] step);
      ucode_type uc;
      uc = '{mul_en: 1'b0, coef: REG_B0, opnd: OPND_D0, acc_op: ACC_NONE,
             w_load: 1'b0, hold_if_full: 1'b0, finish: 1'b0};
      unique case (step)
         4'd0: begin
            uc.mul_en = 1'b1; uc.coef = REG_A1; uc.opnd = OPND_D0;
         end
         4'd1: begin
            uc.mul_en = 1'b1; uc.coef = REG_A2; uc.opnd = OPND_D1;
            uc.acc_op = ACC_FB_SUB;
         end
         4'd2: begin
            uc.mul_en = 1'b1; uc.coef = REG_A3; uc.opnd = OPND_D2;
            uc.acc_op = ACC_FB_SUB;
         end
         4'd3: begin
            uc.mul_en = 1'b1; uc.coef = REG_B1; uc.opnd = OPND_D0;
            uc.acc_op = ACC_FB_SUB;
         end
         4'd4: begin
            uc.mul_en = 1'b1; uc.coef = REG_B2; uc.opnd = OPND_D1;
            uc.acc_op = ACC_Y_ADD; uc.w_load = 1'b1;
         end
         4'd5: begin
            uc.mul_en = 1'b1; uc.coef = REG_B0; uc.opnd = OPND_W;
            uc.acc_op = ACC_Y_ADD;
         end
         4'd6: begin
            uc.mul_en = 1'b1; uc.coef = REG_B3; uc.opnd = OPND_D2;
            uc.acc_op = ACC_Y_ADD;
         end
         4'd7: begin
            uc.acc_op = ACC_Y_ADD;
         end
         4'd8: begin
            uc.hold_if_full = 1'b1; uc.finish = 1'b1;
         end
         default: begin
            uc.finish = 1'b1;
         end
      endcase
      return uc;
   endfunction

endpackage

`default_nettype wire

### src/iir_direct_form2_filter_top.sv
// ----------------------------------------------------------------------------
// iir_direct_form2_filter_top
// direct form II iir filter, up to third order, one shared split multiplier
// ----------------------------------------------------------------------------
// usage:
//   req channel: one item is a 24-bit signed sample plus a last-of-batch flag;
//     taken when req_valid is high and req_stall is low.
//   rsp channel: one item per input item, the saturated 24-bit output and a
//     clipped flag; taken when rsp_valid is high and rsp_stall is low.
//   csr port: apb-style, eight 32-bit registers at 4*i (b0..b3, a1..a3,
//     keep_state); write only while the filter is idle.
// sequencing:
//   a microcoded sequencer runs nine steps per item over one multiplier
//   pair (coefficient times high and low halves of the 40-bit operand), so
//   the result is registered when the last step completes and no new item
//   is taken before then. req_stall is high while an item is in work.
// stall: a finished result waits in the output register; the next item is
//   accepted and runs, holding at its last step until that register frees.
// reset: coefficients go to b0 = 1.0, all else 0, batch mode, delay line
//   cleared, no item pending.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_direct_form2_filter_top #(
   parameter int FILTER_ORDER = iir_pkg::DefFilterOrder
) (
   input  wire                               clock,
   input  wire                               reset,
   // input channel
   input  wire                               req_valid,
   output logic                              req_stall,
   input  iir_pkg::req_type                  req_data,
   // result channel
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output iir_pkg::rsp_type                  rsp_data,
   // configuration port
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire  [iir_pkg::AddrW-1:0]         csr_paddr,
   input  wire  [iir_pkg::DataW-1:0]         csr_pwdata,
   output logic [iir_pkg::DataW-1:0]         csr_prdata,
   output logic                              csr_pready
);

`include "assert_macros.svh"

   localparam int CoefW   = iir_pkg::CoefW;
   localparam int DelayW  = iir_pkg::DelayW;
   localparam int AccW    = iir_pkg::AccW;
   localparam int SampleW = iir_pkg::SampleW;
   localparam int SplitW  = iir_pkg::SplitW;
   localparam int ProdW   = iir_pkg::ProdW;
   localparam int HiW     = DelayW - SplitW;
   localparam int PhiW    = CoefW + HiW;
   localparam int PloW    = CoefW + SplitW + 1;
   localparam int StepW   = iir_pkg::StepW;
   localparam int RndW    = AccW + 1;

   // configuration registers
   logic signed [CoefW-1:0] coef_ff [7];
   logic signed [CoefW-1:0] coef_in [7];
   logic                    keep_ff, keep_in;

   // sequencer
   logic                    busy_ff, busy_in;
   logic [StepW-1:0]        step_ff, step_in;
   iir_pkg::ucode_type      uc;

   // datapath
   logic signed [AccW-1:0]   fb_ff, fb_in;
   logic signed [AccW-1:0]   acc_ff, acc_in;
   logic signed [DelayW-1:0] w_ff, w_in;
   logic signed [PhiW-1:0]   phi_ff, phi_in;
   logic signed [PloW-1:0]   plo_ff, plo_in;
   logic                     hit_ff, hit_in;
   logic                     last_ff, last_in;
   logic signed [DelayW-1:0] dly_ff [FILTER_ORDER];
   logic signed [DelayW-1:0] dly_in [FILTER_ORDER];
   logic signed [DelayW-1:0] tap_val [3];

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   iir_pkg::rsp_type         rsp_data_ff, rsp_data_in;

   // misc combinational
   logic                     req_take, rsp_take, csr_wr, out_full, step_go, finish_go;
   logic signed [CoefW-1:0]  coef_sel;
   logic signed [DelayW-1:0] opnd;
   logic signed [ProdW-1:0]  prod_full;
   logic signed [AccW-1:0]   prod_q;
   logic signed [DelayW-1:0] w_sat;
   logic                     w_hit;
   logic signed [RndW-1:0]   y_rnd;
   logic signed [SampleW-1:0] y_sat;
   logic                     y_hit;
   iir_pkg::reg_idx_type     csr_idx;

   // handshakes
   assign req_take  = req_valid && !busy_ff;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign out_full  = rsp_valid_ff && rsp_stall;
   assign req_stall = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // register file access
   assign csr_pready = 1'b1;
   assign csr_idx    = iir_pkg::reg_idx_type'(csr_paddr[4:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (csr_idx)
         iir_pkg::REG_KEEP: csr_prdata = {{(iir_pkg::DataW-1){1'b0}}, keep_ff};
         default:           csr_prdata = coef_ff[csr_idx];
      endcase
   end

   always_comb begin
      coef_in = coef_ff;
      keep_in = keep_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            iir_pkg::REG_KEEP: keep_in = csr_pwdata[0];
            default:           coef_in[csr_idx] = csr_pwdata;
         endcase
      end
   end

   // delay taps, zero above the filter order
   for (genvar k = 0; k < 3; k++) begin : g_tap
      if (k < FILTER_ORDER) begin : g_used
         assign tap_val[k] = dly_ff[k];
      end else begin : g_unused
         assign tap_val[k] = '0;
      end
   end

   // control word of the current step
   assign uc        = iir_pkg::ucode_rom(step_ff);
   assign step_go   = busy_ff && !(uc.hold_if_full && out_full);
   assign finish_go = step_go && uc.finish;

   // operand selection
   always_comb begin
      unique case (uc.opnd)
         iir_pkg::OPND_D0: opnd = tap_val[0];
         iir_pkg::OPND_D1: opnd = tap_val[1];
         iir_pkg::OPND_D2: opnd = tap_val[2];
         iir_pkg::OPND_W:  opnd = w_ff;
         default:          opnd = w_ff;
      endcase
   end

   always_comb begin
      unique case (uc.coef)
         iir_pkg::REG_KEEP: coef_sel = '0;
         default:           coef_sel = coef_ff[uc.coef];
      endcase
   end

   // split multiply: coefficient times high and low parts of the operand
   always_comb begin
      phi_in = phi_ff;
      plo_in = plo_ff;
      if (step_go && uc.mul_en) begin
         phi_in = coef_sel * $signed(opnd[DelayW-1:SplitW]);
         plo_in = coef_sel * $signed({1'b0, opnd[SplitW-1:0]});
      end
   end

   // recombine and floor back to eight fraction bits
   assign prod_full = ($signed({{(ProdW-PhiW){phi_ff[PhiW-1]}}, phi_ff}) <<< SplitW)
                      + $signed({{(ProdW-PloW){plo_ff[PloW-1]}}, plo_ff});
   assign prod_q    = AccW'(prod_full >>> iir_pkg::CoefFrac);

   // feedback value saturated to the delay width
   always_comb begin
      w_hit = 1'b0;
      w_sat = fb_ff[DelayW-1:0];
      if (fb_ff > $signed({{(AccW-DelayW+1){1'b0}}, {(DelayW-1){1'b1}}})) begin
         w_hit = 1'b1;
         w_sat = {1'b0, {(DelayW-1){1'b1}}};
      end else if (fb_ff < $signed({{(AccW-DelayW+1){1'b1}}, {(DelayW-1){1'b0}}})) begin
         w_hit = 1'b1;
         w_sat = {1'b1, {(DelayW-1){1'b0}}};
      end
   end

   // output rounded half up and saturated
   assign y_rnd = ($signed({acc_ff[AccW-1], acc_ff})
                   + $signed(RndW'(1 << (iir_pkg::FracW - 1)))) >>> iir_pkg::FracW;

   always_comb begin
      y_hit = 1'b0;
      y_sat = y_rnd[SampleW-1:0];
      if (y_rnd > $signed({{(RndW-SampleW+1){1'b0}}, {(SampleW-1){1'b1}}})) begin
         y_hit = 1'b1;
         y_sat = {1'b0, {(SampleW-1){1'b1}}};
      end else if (y_rnd < $signed({{(RndW-SampleW+1){1'b1}}, {(SampleW-1){1'b0}}})) begin
         y_hit = 1'b1;
         y_sat = {1'b1, {(SampleW-1){1'b0}}};
      end
   end

   // sequencer and accumulators
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      fb_in   = fb_ff;
      acc_in  = acc_ff;
      w_in    = w_ff;
      hit_in  = hit_ff;
      last_in = last_ff;
      if (req_take) begin
         busy_in = 1'b1;
         step_in = '0;
         fb_in   = $signed({{(AccW-SampleW){req_data.sample_in[SampleW-1]}},
                            req_data.sample_in}) <<< iir_pkg::FracW;
         acc_in  = '0;
         hit_in  = 1'b0;
         last_in = req_data.last_of_batch;
      end else if (step_go) begin
         if (uc.finish) begin
            busy_in = 1'b0;
            step_in = '0;
         end else begin
            step_in = step_ff + 1'b1;
         end
         unique case (uc.acc_op)
            iir_pkg::ACC_FB_SUB: fb_in  = fb_ff - prod_q;
            iir_pkg::ACC_Y_ADD:  acc_in = acc_ff + prod_q;
            default: ;
         endcase
         if (uc.w_load) begin
            w_in   = w_sat;
            hit_in = hit_ff | w_hit;
         end
      end
   end

   // delay line shift and batch clear
   always_comb begin
      dly_in = dly_ff;
      if (finish_go) begin
         for (int k = FILTER_ORDER - 1; k >= 1; k--) begin
            dly_in[k] = dly_ff[k-1];
         end
         dly_in[0] = w_ff;
         if (last_ff && !keep_ff) begin
            for (int k = 0; k < FILTER_ORDER; k++) begin
               dly_in[k] = '0;
            end
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
      if (finish_go) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.sample_out = y_sat;
         rsp_data_in.clipped    = hit_ff | y_hit;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[iir_pkg::REG_B0] <= iir_pkg::CoefB0Reset;
         for (int k = 1; k < 7; k++) begin
            coef_ff[k] <= '0;
         end
         keep_ff      <= 1'b0;
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < FILTER_ORDER; k++) begin
            dly_ff[k] <= '0;
         end
      end else begin
         coef_ff      <= coef_in;
         keep_ff      <= keep_in;
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         dly_ff       <= dly_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      fb_ff       <= fb_in;
      acc_ff      <= acc_in;
      w_ff        <= w_in;
      phi_ff      <= phi_in;
      plo_ff      <= plo_in;
      hit_ff      <= hit_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   // checks
   `ASSERT_IMPLIES(a_step_range, clock, reset, busy_ff, step_ff < StepW'(iir_pkg::UcodeSteps),
      "step counter beyond program")
   `ASSERT_IMPLIES(a_idle_step, clock, reset, !busy_ff, step_ff == '0,
      "step counter not parked while idle")
   `ASSERT_NEXT(a_finish_out, clock, reset, finish_go, rsp_valid_ff && !busy_ff,
      "finished item did not reach the output register")

endmodule

`default_nettype wire
